/* rtl/core/pppt_pkg.sv */
`default_nettype none
package pppt_pkg;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int ADDR_WIDTH = 4;
    localparam logic [ADDR_WIDTH-1:0] ADDR_QUERY_X = 4'h0;
    localparam logic [ADDR_WIDTH-1:0] ADDR_QUERY_Y = 4'h4;
    localparam logic [ADDR_WIDTH-1:0] ADDR_NEAR_DIST = 4'h8;
    localparam logic [ADDR_WIDTH-1:0] ADDR_STRICT = 4'hc;
endpackage
`default_nettype wire

/* rtl/core/polyline_point_proximity_test_core.sv */
`default_nettype none
// channel | valid          | stall     | payload
// in      | in_valid       | in_stall  | vertex_x, vertex_y, part_start, last_vertex
// out     | out_valid      | out_stall | is_near
// cfg     | psel & penable | pready    | pwrite, paddr, pwdata
// a tested segment runs seven products through one bit-serial shift-add multiplier,
// one multiplier bit per cycle, so the input stalls after the vertex that closes it
// until the last product ends; other items do not start the multiplier.
// a result is valid the cycle after its item, or when the last product ends; while it
// waits under out_stall the input stalls too. reset clears control state and all registers;
// the user writes configuration only while no segment is in flight; the core does not check.
module polyline_point_proximity_test_core
#(
    parameter int COORD_WIDTH = pppt_pkg::COORD_WIDTH_DEF
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [pppt_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  wire                         in_valid,
    output logic                        in_stall,
    input  wire signed [COORD_WIDTH-1:0] vertex_x,
    input  wire signed [COORD_WIDTH-1:0] vertex_y,
    input  wire                         part_start,
    input  wire                         last_vertex,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic                        is_near
);
    import pppt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 2;          // differences incl. widened box
    localparam int PW = 2 * DW;          // products of differences
    localparam int LW = 4 * DW + 2;      // final products
    localparam int CNTW = $clog2(2 * DW + 2);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_CROSS1 = 8'b00000010,
        S_CROSS2 = 8'b00000100,
        S_LEN    = 8'b00001000,
        S_LEN2   = 8'b00010000,
        S_DIST   = 8'b00100000,
        S_LHS    = 8'b01000000,
        S_RHS    = 8'b10000000
    } state_t;

    logic signed [CW-1:0] qx_reg, qy_reg;
    logic [CW-2:0] nd_reg;
    logic strict_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;
    logic prev_valid_reg, hit_reg, last_reg;
    logic out_valid_reg, is_near_reg;
    state_t state_reg, state_next;

    logic [DW-1:0] dx_reg, dy_reg, px_reg;   // magnitudes
    logic sdx_reg, sdy_reg, spx_reg, spy_reg;
    logic signed [PW:0] cross_reg;                   // signed cross
    logic [PW:0] len_reg, d2_reg;
    logic [LW-1:0] lhs_reg;
    // shared serial multiplier
    logic [LW-1:0] mcand_reg, acc_reg;
    logic [PW:0] mplier_reg;
    logic [CNTW-1:0] cnt_reg;
    logic mul_done;

    wire wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr)
            ADDR_QUERY_X:   prdata = 32'(unsigned'(qx_reg)) & 32'((64'd1 << CW) - 1);
            ADDR_QUERY_Y:   prdata = 32'(unsigned'(qy_reg)) & 32'((64'd1 << CW) - 1);
            ADDR_NEAR_DIST: prdata = 32'(nd_reg);
            ADDR_STRICT:    prdata = {31'd0, strict_reg};
            default:        prdata = 32'd0;
        endcase
    end

    wire in_acc = in_valid && !in_stall;
    wire out_busy = out_valid_reg && out_stall;
    assign in_stall = (state_reg != S_IDLE) || out_busy;
    assign out_valid = out_valid_reg;
    assign is_near = is_near_reg;

    // bounding box and differences at accept
    logic signed [DW-1:0] ax, ay, bx, by, qx, qy, dd;
    logic signed [DW-1:0] ddx, ddy, dpx, dpy;
    logic in_box, seg_ok;
    always_comb
    begin
        ax = DW'(prev_x_reg); ay = DW'(prev_y_reg);
        bx = DW'(vertex_x);   by = DW'(vertex_y);
        qx = DW'(qx_reg);     qy = DW'(qy_reg);
        dd = DW'({1'b0, nd_reg});
        ddx = bx - ax; ddy = by - ay; dpx = qx - ax; dpy = qy - ay;
        in_box = !(qx < ((ax < bx) ? ax : bx) - dd) && !(qx > ((ax < bx) ? bx : ax) + dd)
              && !(qy < ((ay < by) ? ay : by) - dd) && !(qy > ((ay < by) ? by : ay) + dd);
        seg_ok = !part_start && prev_valid_reg && in_box && (ddx != 0 || ddy != 0);
    end

    assign mul_done = (cnt_reg == CNTW'(PW + 1));
    wire [LW-1:0] acc_step = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
    logic [LW-1:0] prod;
    assign prod = acc_step;

    logic signed [PW+1:0] cr_sum;
    logic [PW:0] cr_mag;
    always_comb
    begin
        cr_sum = (sdy_reg ^ spx_reg) ? (PW+2)'(cross_reg) + (PW+2)'(prod)
                                     : (PW+2)'(cross_reg) - (PW+2)'(prod);
        cr_mag = cr_sum[PW+1] ? (PW+1)'(-cr_sum) : (PW+1)'(cr_sum);
    end

    logic seg_hit;
    assign seg_hit = strict_reg ? (lhs_reg < prod) : (lhs_reg <= prod);

    logic out_load;
    assign out_load = (in_acc && !seg_ok && last_vertex)
                   || ((state_reg == S_RHS) && mul_done && last_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in_acc && seg_ok) state_next = S_CROSS1;
            S_CROSS1: if (mul_done) state_next = S_CROSS2;
            S_CROSS2: if (mul_done) state_next = S_LEN;
            S_LEN:    if (mul_done) state_next = S_LEN2;
            S_LEN2:   if (mul_done) state_next = S_DIST;
            S_DIST:   if (mul_done) state_next = S_LHS;
            S_LHS:    if (mul_done) state_next = S_RHS;
            S_RHS:    if (mul_done) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0; qy_reg <= '0; nd_reg <= '0; strict_reg <= 1'b0;
            prev_x_reg <= '0; prev_y_reg <= '0;
            prev_valid_reg <= 1'b0; hit_reg <= 1'b0; last_reg <= 1'b0;
            out_valid_reg <= 1'b0; is_near_reg <= 1'b0;
            state_reg <= S_IDLE; cnt_reg <= '0;
            dx_reg <= '0; dy_reg <= '0; px_reg <= '0;
            sdx_reg <= 1'b0; sdy_reg <= 1'b0; spx_reg <= 1'b0; spy_reg <= 1'b0;
            cross_reg <= '0; len_reg <= '0; d2_reg <= '0; lhs_reg <= '0;
            mcand_reg <= '0; mplier_reg <= '0; acc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr)
            begin
                case (paddr)
                    ADDR_QUERY_X:   qx_reg <= pwdata[CW-1:0];
                    ADDR_QUERY_Y:   qy_reg <= pwdata[CW-1:0];
                    ADDR_NEAR_DIST: nd_reg <= pwdata[CW-2:0];
                    ADDR_STRICT:    strict_reg <= pwdata[0];
                    default: ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (in_acc)
            begin
                prev_x_reg <= vertex_x; prev_y_reg <= vertex_y;
                last_reg <= last_vertex;
                if (!seg_ok && last_vertex)
                begin
                    is_near_reg <= hit_reg;
                    hit_reg <= 1'b0; prev_valid_reg <= 1'b0;
                end
                else
                    prev_valid_reg <= 1'b1;
                dx_reg <= ddx[DW-1] ? -ddx : ddx; sdx_reg <= ddx[DW-1];
                dy_reg <= ddy[DW-1] ? -ddy : ddy; sdy_reg <= ddy[DW-1];
                px_reg <= dpx[DW-1] ? -dpx : dpx; spx_reg <= dpx[DW-1];
                spy_reg <= dpy[DW-1];
                // first product dx*py
                mcand_reg <= LW'(ddx[DW-1] ? -ddx : ddx);
                mplier_reg <= (PW+1)'(dpy[DW-1] ? -dpy : dpy);
                acc_reg <= '0; cnt_reg <= '0;
            end
            else if (state_reg != S_IDLE)
            begin
                if (!mul_done)
                begin
                    acc_reg <= acc_step;
                    mcand_reg <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                begin
                    // dy*dy added through preloaded accumulator
                    acc_reg <= (state_reg == S_LEN) ? prod : '0;
                    cnt_reg <= '0;
                    case (state_reg)
                        S_CROSS1:
                        begin
                            cross_reg <= (sdx_reg ^ spy_reg) ? -(PW+1)'(prod) : (PW+1)'(prod);
                            mcand_reg <= LW'(dy_reg); mplier_reg <= (PW+1)'(px_reg);
                        end
                        S_CROSS2:
                        begin
                            cross_reg <= $signed(cr_mag);
                            mcand_reg <= LW'(dx_reg); mplier_reg <= (PW+1)'(dx_reg);
                        end
                        S_LEN:
                        begin
                            mcand_reg <= LW'(dy_reg); mplier_reg <= (PW+1)'(dy_reg);
                        end
                        S_LEN2:
                        begin
                            len_reg <= (PW+1)'(prod);
                            mcand_reg <= LW'(nd_reg); mplier_reg <= (PW+1)'(nd_reg);
                        end
                        S_DIST:
                        begin
                            d2_reg <= (PW+1)'(prod);
                            mcand_reg <= LW'(cross_reg); mplier_reg <= cross_reg;
                        end
                        S_LHS:
                        begin
                            lhs_reg <= prod;
                            mcand_reg <= LW'(d2_reg); mplier_reg <= len_reg;
                        end
                        S_RHS:
                        begin
                            if (last_reg)
                            begin
                                is_near_reg <= hit_reg || seg_hit;
                                hit_reg <= 1'b0; prev_valid_reg <= 1'b0;
                            end
                            else if (seg_hit)
                                hit_reg <= 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("accepted item while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(is_near)))
        else $error("result dropped");
`endif
endmodule
`default_nettype wire
